// File: design/gneg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gneg_pkg
// shared types and constants of the grid neighbor edge generator
// ---------------------------------------------------------------------------
package gneg_pkg;

  localparam int MAX_DIM        = 256;
  localparam int MAX_NEIGHBOURS = 8;
  localparam int NODE_W         = 16;
  localparam int DIM_W          = 9;
  localparam int GREY_W         = 8;
  localparam int COST_W         = 10;
  localparam int STORE_DEPTH    = 65536;
  localparam int DIR_W          = $clog2(MAX_NEIGHBOURS);
  localparam int DIM_LIMIT      = (MAX_DIM > (2 ** DIM_W) - 1) ? (2 ** DIM_W) - 1 : MAX_DIM;
  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DIM_LIMIT);

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_LEFT  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_UP    = 3'd2,
    DIR_DOWN  = 3'd3,
    DIR_UL    = 3'd4,
    DIR_UR    = 3'd5,
    DIR_DL    = 3'd6,
    DIR_DR    = 3'd7
  } dir_t;

  typedef struct packed {
    logic              done;
    logic [NODE_W-1:0] quot;
    logic [DIM_W-1:0]  rem;
  } div_res_t;

endpackage : gneg_pkg
`default_nettype wire

// File: design/gneg_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gneg_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module gneg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : gneg_ram
`default_nettype wire

// File: design/gneg_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gneg_div
// restoring divider, one quotient bit per cycle, splits a node id into row
// and column
// ---------------------------------------------------------------------------
module gneg_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [gneg_pkg::NODE_W-1:0] dividend,
  input  wire logic [gneg_pkg::DIM_W-1:0]  divisor,
  output      gneg_pkg::div_res_t          res
);
  import gneg_pkg::*;

  localparam int CNT_W = $clog2(NODE_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIM_W-1:0]  rem_r;
  logic [NODE_W-1:0] quot_r;
  logic [DIM_W-1:0]  dvs_r;
  logic [DIM_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, quot_r[NODE_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NODE_W);
        rem_r  <= '0;
        quot_r <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= fits ? DIM_W'(trial - {1'b0, dvs_r}) : trial[DIM_W-1:0];
        quot_r <= {quot_r[NODE_W-2:0], fits};
        cnt_r  <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r;
  assign res.rem  = rem_r;

endmodule : gneg_div
`default_nettype wire

// File: design/grid_neighbor_edge_generator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// grid_neighbor_edge_generator_unit
// eight-connected neighbor expansion over a loaded greyscale map
// ---------------------------------------------------------------------------
// A load item writes one map cell; the block stays ready.
// A query item holds the block busy until the query is closed: first the
// bit-serial divider splits the node id into row and column, then each
// in-grid neighbor gets a map read through the single read port of the map
// ram and a check, a neighbor off the grid is skipped in the read state, and
// a final state closes the query; the result side can stall checks and close.
// A node outside the grid goes straight to the close. Results come in the
// order left, right, up, down, up-left, up-right, down-left, down-right; the
// final one carries last, and a query with no walkable neighbor gives a single
// item with has_edge low.
// ---------------------------------------------------------------------------
module grid_neighbor_edge_generator_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [gneg_pkg::DIM_W-1:0]  cfg_wdata,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic                        in_operation,
  input  wire logic [gneg_pkg::NODE_W-1:0] in_cell_index,
  input  wire logic [gneg_pkg::GREY_W-1:0] in_cell_value,
  input  wire logic [gneg_pkg::NODE_W-1:0] in_node_id,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic                        out_has_edge,
  output      logic [gneg_pkg::NODE_W-1:0] out_target_node,
  output      logic [gneg_pkg::COST_W-1:0] out_edge_cost,
  output      logic                        out_is_diagonal,
  output      logic                        out_last
);
  import gneg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_CHK,
    S_FIN
  } state_t;

  state_t            state_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic [NODE_W-1:0] node_r;
  logic [DIM_W-1:0]  col_r;
  logic [NODE_W-1:0] row_r;
  dir_t              dir_r;

  logic              pend_v_r;
  logic [NODE_W-1:0] pend_id_r;
  logic [COST_W-1:0] pend_cost_r;
  logic              pend_diag_r;

  logic              out_valid_r;
  logic              out_has_edge_r;
  logic [NODE_W-1:0] out_target_r;
  logic [COST_W-1:0] out_cost_r;
  logic              out_diag_r;
  logic              out_last_r;

  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic              in_acc;
  logic              div_start;
  div_res_t          div_res;
  logic              ram_we;
  logic              ram_re;
  logic [NODE_W-1:0] nb_id;
  logic [NODE_W-1:0] nb_off;
  logic              nb_ok;
  logic              has_l;
  logic              has_r;
  logic              has_u;
  logic              has_d;
  logic              nb_diag;
  logic [GREY_W-1:0] grey;
  logic [DIM_W-1:0]  inv_grey;
  logic [COST_W-1:0] nb_cost;
  logic              out_free;
  logic              out_load;
  logic              last_dir;

  // register values out of range are clamped
  always_comb begin
    w_eff = width_r;
    if (width_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (width_r > DIM_CAP) begin
      w_eff = DIM_CAP;
    end
    h_eff = height_r;
    if (height_r == '0) begin
      h_eff = DIM_W'(1);
    end else if (height_r > DIM_CAP) begin
      h_eff = DIM_CAP;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign ram_we    = in_acc && (in_operation == OP_LOAD);
  assign div_start = in_acc && (in_operation == OP_QUERY);
  assign out_free  = !out_valid_r || out_ready;
  assign last_dir  = (dir_r == DIR_DR);
  assign out_load  = ((state_r == S_CHK) && (grey != '0) && pend_v_r && out_free) ||
                     ((state_r == S_FIN) && out_free);

  gneg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_node_id),
    .divisor  (w_eff),
    .res      (div_res)
  );

  // neighbor position and grid-edge checks
  assign has_l   = (col_r != '0);
  assign has_r   = ({1'b0, col_r} + (DIM_W+1)'(1)) < {1'b0, w_eff};
  assign has_u   = (row_r != '0);
  assign has_d   = ({1'b0, row_r} + (NODE_W+1)'(1)) < (NODE_W+1)'(h_eff);
  assign nb_diag = (dir_r == DIR_UL) || (dir_r == DIR_UR) ||
                   (dir_r == DIR_DL) || (dir_r == DIR_DR);

  always_comb begin
    unique case (dir_r)
      DIR_LEFT: begin
        nb_ok  = has_l;
        nb_off = '1;
      end
      DIR_RIGHT: begin
        nb_ok  = has_r;
        nb_off = NODE_W'(1);
      end
      DIR_UP: begin
        nb_ok  = has_u;
        nb_off = NODE_W'(0) - NODE_W'(w_eff);
      end
      DIR_DOWN: begin
        nb_ok  = has_d;
        nb_off = NODE_W'(w_eff);
      end
      DIR_UL: begin
        nb_ok  = has_u && has_l;
        nb_off = NODE_W'(0) - NODE_W'(w_eff) - NODE_W'(1);
      end
      DIR_UR: begin
        nb_ok  = has_u && has_r;
        nb_off = NODE_W'(1) - NODE_W'(w_eff);
      end
      DIR_DL: begin
        nb_ok  = has_d && has_l;
        nb_off = NODE_W'(w_eff) - NODE_W'(1);
      end
      DIR_DR: begin
        nb_ok  = has_d && has_r;
        nb_off = NODE_W'(w_eff) + NODE_W'(1);
      end
      default: begin
        nb_ok  = 1'b0;
        nb_off = '0;
      end
    endcase
  end

  assign nb_id = node_r + nb_off;

  // nb_id is held stable from the read cycle to the check cycle
  assign ram_re = (state_r == S_RD) && nb_ok;

  gneg_ram #(
    .WIDTH (GREY_W),
    .DEPTH (STORE_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_cell_index),
    .wdata (in_cell_value),
    .re    (ram_re),
    .raddr (nb_id),
    .rdata (grey)
  );

  assign inv_grey = DIM_W'(256) - {1'b0, grey};
  assign nb_cost  = nb_diag ? (COST_W'({inv_grey, 1'b0}) + COST_W'(inv_grey))
                            : COST_W'({inv_grey, 1'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= DIM_W'(256);
      height_r    <= DIM_W'(256);
      dir_r       <= DIR_LEFT;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_GRID_WIDTH:  width_r  <= cfg_wdata;
          REG_GRID_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (div_start) begin
            node_r   <= in_node_id;
            pend_v_r <= 1'b0;
            state_r  <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            col_r <= div_res.rem;
            row_r <= div_res.quot;
            dir_r <= DIR_LEFT;
            // node beyond the last row gives no edge
            if (div_res.quot >= NODE_W'(h_eff)) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          if (nb_ok) begin
            state_r <= S_CHK;
          end else if (last_dir) begin
            state_r <= S_FIN;
          end else begin
            dir_r <= dir_t'(dir_r + DIR_W'(1));
          end
        end
        S_CHK: begin
          if (grey == '0 || !pend_v_r || out_free) begin
            if (grey != '0) begin
              if (pend_v_r) begin
                out_has_edge_r <= 1'b1;
                out_target_r   <= pend_id_r;
                out_cost_r     <= pend_cost_r;
                out_diag_r     <= pend_diag_r;
                out_last_r     <= 1'b0;
              end
              pend_v_r    <= 1'b1;
              pend_id_r   <= nb_id;
              pend_cost_r <= nb_cost;
              pend_diag_r <= nb_diag;
            end
            if (last_dir) begin
              state_r <= S_FIN;
            end else begin
              dir_r   <= dir_t'(dir_r + DIR_W'(1));
              state_r <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_has_edge_r <= pend_v_r;
            out_target_r   <= pend_v_r ? pend_id_r : '0;
            out_cost_r     <= pend_v_r ? pend_cost_r : '0;
            out_diag_r     <= pend_v_r && pend_diag_r;
            out_last_r     <= 1'b1;
            pend_v_r       <= 1'b0;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_has_edge    = out_has_edge_r;
  assign out_target_node = out_target_r;
  assign out_edge_cost   = out_cost_r;
  assign out_is_diagonal = out_diag_r;
  assign out_last        = out_last_r;

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

  a_no_edge_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_has_edge_r) |-> out_last_r)
    else $error("empty result item without last");

  a_edge_cost_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_has_edge_r) |-> (out_cost_r != '0))
    else $error("edge item with zero cost");

  a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (state_r == S_IDLE && out_valid_r && out_last_r))
    else $error("query did not close with a last item");

endmodule : grid_neighbor_edge_generator_unit
`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the grid neighbor edge generator unit
// ---------------------------------------------------------------------------
// A short directed table loads map cells and queries corner, edge and
// off-grid nodes under the reset grid and under clamped grid sizes. Random
// phases follow, each with new grid sizes: before each query the bench
// loads every in-grid neighbor not yet written, so that no unwritten map
// cell is ever read. Expected edges come from an in-bench model of the
// neighbor search and are compared in order with every item on the result
// side. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
module tb;
  import gneg_pkg::*;

  localparam int RAND_ITEMS  = 230;
  localparam int DRAIN       = 64;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic              has_edge;
    logic [NODE_W-1:0] target_node;
    logic [COST_W-1:0] edge_cost;
    logic              is_diagonal;
    logic              last;
  } edge_t;

  typedef enum logic {ROW_ITEM, ROW_SETUP} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    op_t               op;
    logic [NODE_W-1:0] map_idx;
    logic [GREY_W-1:0] grey;
    logic [NODE_W-1:0] node;
    bit                typed;
    edge_t             want;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
  } step_row_t;

  localparam edge_t NO_EDGE = '{1'b0, 16'd0, 10'd0, 1'b0, 1'b1};

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                cfg_we        = 1'b0;
  logic                cfg_index     = 1'b0;
  logic [DIM_W-1:0]    cfg_wdata     = '0;
  logic                in_valid      = 1'b0;
  logic                in_ready;
  logic                in_operation  = 1'b0;
  logic [NODE_W-1:0]   in_cell_index = '0;
  logic [GREY_W-1:0]   in_cell_value = '0;
  logic [NODE_W-1:0]   in_node_id    = '0;
  logic                out_valid;
  logic                out_ready     = 1'b0;
  logic                out_has_edge;
  logic [NODE_W-1:0]   out_target_node;
  logic [COST_W-1:0]   out_edge_cost;
  logic                out_is_diagonal;
  logic                out_last;

  logic [GREY_W-1:0]   grey_map [0:STORE_DEPTH-1];
  bit                  cell_loaded [0:STORE_DEPTH-1];
  logic [DIM_W-1:0]    width_reg  = 9'd256;
  logic [DIM_W-1:0]    height_reg = 9'd256;
  edge_t               pending_edges [$];
  step_row_t           steps [$];
  bit                  calm        = 1'b0;
  int                  stall_left  = 0;
  int                  items_sent  = 0;
  int                  error_count = 0;
  int                  cycle_count = 0;

  grid_neighbor_edge_generator_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_cell_index   (in_cell_index),
    .in_cell_value   (in_cell_value),
    .in_node_id      (in_node_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_has_edge    (out_has_edge),
    .out_target_node (out_target_node),
    .out_edge_cost   (out_edge_cost),
    .out_is_diagonal (out_is_diagonal),
    .out_last        (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [GREY_W-1:0] pick_grey();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r == 3) return 8'd255;
    if (r == 4) return 8'd1;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int unsigned pick_coord(input int unsigned n);
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 0;
    if (r < 6) return n - 1;
    return $urandom_range(0, n - 1);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 9'd1;
      2:       return 9'd2;
      3:       return 9'd255;
      4:       return 9'd256;
      5:       return 9'd511;
      6:       return 9'($urandom_range(257, 510));
      default: return 9'($urandom_range(3, 24));
    endcase
  endfunction

  // in-grid flags and linear ids of the eight neighbors, in search order
  function automatic void find_neighbors(input logic [NODE_W-1:0] node,
                                         output logic [7:0] in_grid,
                                         output logic [7:0][NODE_W-1:0] ids);
    int unsigned w, h, n, x, y;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    n = node;
    in_grid = '0;
    ids = '0;
    if (n < w * h) begin
      x = n % w;
      y = n / w;
      in_grid[DIR_LEFT]  = x > 0;
      in_grid[DIR_RIGHT] = x + 1 < w;
      in_grid[DIR_UP]    = y > 0;
      in_grid[DIR_DOWN]  = y + 1 < h;
      in_grid[DIR_UL]    = in_grid[DIR_UP] && in_grid[DIR_LEFT];
      in_grid[DIR_UR]    = in_grid[DIR_UP] && in_grid[DIR_RIGHT];
      in_grid[DIR_DL]    = in_grid[DIR_DOWN] && in_grid[DIR_LEFT];
      in_grid[DIR_DR]    = in_grid[DIR_DOWN] && in_grid[DIR_RIGHT];
      ids[DIR_LEFT]  = 16'(n - 1);
      ids[DIR_RIGHT] = 16'(n + 1);
      ids[DIR_UP]    = 16'(n - w);
      ids[DIR_DOWN]  = 16'(n + w);
      ids[DIR_UL]    = 16'(n - w - 1);
      ids[DIR_UR]    = 16'(n - w + 1);
      ids[DIR_DL]    = 16'(n + w - 1);
      ids[DIR_DR]    = 16'(n + w + 1);
    end
  endfunction

  // queue the edges a query of this node must produce
  task automatic expand_node(input logic [NODE_W-1:0] node);
    logic [7:0]              in_grid;
    logic [7:0][NODE_W-1:0]  ids;
    edge_t                   hits [$];
    edge_t                   e;
    dir_t                    d;
    logic [GREY_W-1:0]       grey;
    find_neighbors(node, in_grid, ids);
    for (int k = 0; k < MAX_NEIGHBOURS; k++) begin
      d = dir_t'(k);
      grey = grey_map[ids[k]];
      if (in_grid[k] && grey != 0) begin
        e.has_edge    = 1'b1;
        e.target_node = ids[k];
        e.is_diagonal = d >= DIR_UL;
        e.edge_cost   = COST_W'((256 - grey) * (e.is_diagonal ? 3 : 2));
        e.last        = 1'b0;
        hits.push_back(e);
      end
    end
    if (hits.size() == 0) begin
      pending_edges.push_back(NO_EDGE);
    end else begin
      foreach (hits[i]) begin
        e = hits[i];
        e.last = i == hits.size() - 1;
        pending_edges.push_back(e);
      end
    end
  endtask

  task automatic report(input string what);
    $display("ERROR cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic send_item(input op_t op, input logic [NODE_W-1:0] map_idx,
                           input logic [GREY_W-1:0] grey, input logic [NODE_W-1:0] node,
                           input bit typed, input edge_t want);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_cell_index <= (op == OP_LOAD) ? map_idx : 16'($urandom);
    in_cell_value <= (op == OP_LOAD) ? grey : 8'($urandom);
    in_node_id    <= (op == OP_QUERY) ? node : 16'($urandom);
    do @(posedge clk); while (in_ready !== 1'b1);
    items_sent++;
    if (op == OP_LOAD) begin
      grey_map[map_idx]    = grey;
      cell_loaded[map_idx] = 1'b1;
    end else if (typed) begin
      pending_edges.push_back(want);
    end else begin
      expand_node(node);
    end
  endtask

  // grid size changes only once the block has gone quiet
  task automatic set_dims(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we     <= 1'b0;
    width_reg  = w;
    height_reg = h;
  endtask

  function automatic step_row_t item_row(input op_t op, input logic [NODE_W-1:0] map_idx,
                                         input logic [GREY_W-1:0] grey,
                                         input logic [NODE_W-1:0] node,
                                         input bit typed, input edge_t want);
    step_row_t r;
    r.kind    = ROW_ITEM;
    r.op      = op;
    r.map_idx = map_idx;
    r.grey    = grey;
    r.node    = node;
    r.typed   = typed;
    r.want    = want;
    r.w       = '0;
    r.h       = '0;
    return r;
  endfunction

  function automatic step_row_t dims_row(input logic [DIM_W-1:0] w,
                                         input logic [DIM_W-1:0] h);
    step_row_t r;
    r = item_row(OP_LOAD, '0, '0, '0, 1'b0, '0);
    r.kind = ROW_SETUP;
    r.w    = w;
    r.h    = h;
    return r;
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 30) begin
      out_ready  <= 1'b0;
      stall_left <= pick_gap() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    edge_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_edges.size() == 0) begin
        report("result item with nothing pending");
      end else begin
        want = pending_edges.pop_front();
        if (out_has_edge !== want.has_edge)
          report($sformatf("has_edge %b, want %b", out_has_edge, want.has_edge));
        if (out_target_node !== want.target_node)
          report($sformatf("target_node %0d, want %0d", out_target_node, want.target_node));
        if (out_edge_cost !== want.edge_cost)
          report($sformatf("edge_cost %0d, want %0d", out_edge_cost, want.edge_cost));
        if (out_is_diagonal !== want.is_diagonal)
          report($sformatf("is_diagonal %b, want %b", out_is_diagonal, want.is_diagonal));
        if (out_last !== want.last)
          report($sformatf("last %b, want %b", out_last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    logic [7:0]             in_grid;
    logic [7:0][NODE_W-1:0] ids;
    logic [NODE_W-1:0]      node;
    int unsigned            w, h, area, span, r;

    // reset grid is 256 x 256
    steps.push_back(item_row(OP_LOAD, 16'd1, 8'd255, '0, 1'b0, '0));
    steps.push_back(item_row(OP_LOAD, 16'd256, 8'd1, '0, 1'b0, '0));
    steps.push_back(item_row(OP_LOAD, 16'd257, 8'd0, '0, 1'b0, '0));
    steps.push_back(item_row(OP_QUERY, '0, '0, 16'd0, 1'b0, '0));
    steps.push_back(item_row(OP_LOAD, 16'd65534, 8'd0, '0, 1'b0, '0));
    steps.push_back(item_row(OP_LOAD, 16'd65279, 8'd0, '0, 1'b0, '0));
    steps.push_back(item_row(OP_LOAD, 16'd65278, 8'd0, '0, 1'b0, '0));
    steps.push_back(item_row(OP_QUERY, '0, '0, 16'd65535, 1'b1, NO_EDGE));
    steps.push_back(item_row(OP_LOAD, 16'd65279, 8'd128, '0, 1'b0, '0));
    steps.push_back(item_row(OP_QUERY, '0, '0, 16'd65535, 1'b1,
                             '{1'b1, 16'd65279, 10'd256, 1'b0, 1'b1}));
    steps.push_back(item_row(OP_LOAD, 16'd65278, 8'd1, '0, 1'b0, '0));
    steps.push_back(item_row(OP_QUERY, '0, '0, 16'd65535, 1'b0, '0));
    steps.push_back(item_row(OP_LOAD, 16'd65535, 8'd255, '0, 1'b0, '0));
    // zero sizes clamp to a single cell
    steps.push_back(dims_row(9'd0, 9'd0));
    steps.push_back(item_row(OP_QUERY, '0, '0, 16'd0, 1'b1, NO_EDGE));
    steps.push_back(item_row(OP_QUERY, '0, '0, 16'd1, 1'b1, NO_EDGE));
    // oversized width clamps to 256
    steps.push_back(dims_row(9'd511, 9'd3));
    steps.push_back(item_row(OP_LOAD, 16'd0, 8'd64, '0, 1'b0, '0));
    steps.push_back(item_row(OP_LOAD, 16'd512, 8'd200, '0, 1'b0, '0));
    steps.push_back(item_row(OP_LOAD, 16'd513, 8'd0, '0, 1'b0, '0));
    steps.push_back(item_row(OP_QUERY, '0, '0, 16'd256, 1'b0, '0));
    steps.push_back(item_row(OP_QUERY, '0, '0, 16'd768, 1'b1, NO_EDGE));
    // single column
    steps.push_back(dims_row(9'd1, 9'd256));
    steps.push_back(item_row(OP_LOAD, 16'd4, 8'd10, '0, 1'b0, '0));
    steps.push_back(item_row(OP_LOAD, 16'd6, 8'd0, '0, 1'b0, '0));
    steps.push_back(item_row(OP_QUERY, '0, '0, 16'd5, 1'b1,
                             '{1'b1, 16'd4, 10'd492, 1'b0, 1'b1}));
    steps.push_back(item_row(OP_QUERY, '0, '0, 16'd0, 1'b1,
                             '{1'b1, 16'd1, 10'd2, 1'b0, 1'b1}));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steps[i]) begin
      if (steps[i].kind == ROW_SETUP)
        set_dims(steps[i].w, steps[i].h);
      else
        send_item(steps[i].op, steps[i].map_idx, steps[i].grey, steps[i].node,
                  steps[i].typed, steps[i].want);
    end

    while (items_sent < RAND_ITEMS) begin
      set_dims(pick_dim(), pick_dim());
      calm = $urandom_range(0, 3) == 0;
      w    = clamp_dim(width_reg);
      h    = clamp_dim(height_reg);
      area = w * h;
      span = $urandom_range(25, 45);
      repeat (span) begin
        if (items_sent >= RAND_ITEMS) break;
        r = $urandom_range(0, 99);
        if (r < 12) begin
          send_item(OP_LOAD, 16'($urandom), pick_grey(), '0, 1'b0, '0);
        end else if (r < 22 && area < STORE_DEPTH) begin
          send_item(OP_QUERY, '0, '0, 16'($urandom_range(area, STORE_DEPTH - 1)), 1'b0, '0);
        end else begin
          node = 16'(pick_coord(h) * w + pick_coord(w));
          find_neighbors(node, in_grid, ids);
          // write every neighbor the query will read that is not yet loaded, now and then rewrite one
          for (int k = 0; k < MAX_NEIGHBOURS; k++) begin
            if (in_grid[k] && (!cell_loaded[ids[k]] || $urandom_range(0, 9) == 0))
              send_item(OP_LOAD, ids[k], pick_grey(), '0, 1'b0, '0);
          end
          send_item(OP_QUERY, '0, '0, node, 1'b0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
